>>> hdl/svalloc_pkg.sv
// svalloc_pkg: widths, codes, constants and control/status types of the voice allocator
// no dependencies; imported by svalloc_ctrl, svalloc_dp and synth_voice_allocator_core
`timescale 1ns / 1ps

package svalloc_pkg;

    // field widths
    localparam int REQ_W      = 3;
    localparam int NOTE_W     = 7;
    localparam int CHAN_W     = 4;
    localparam int ARG_W      = 14;
    localparam int CTL_W      = 7;
    localparam int CMD_W      = 3;
    localparam int VIDX_W     = 5;
    localparam int ONOTE_W    = 8;
    localparam int OARG_W     = 21;
    localparam int PATCH_W    = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int VIU_W      = 6;
    localparam int SCALE_W    = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_VOICES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FM_DRUM_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_SHIFT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_SCALE  = 2'd3;

    localparam logic [VIU_W-1:0]   RESET_VOICES = 6'd32;
    localparam logic [SCALE_W-1:0] RESET_SCALE  = 7'd100;

    // voice pool
    localparam int DEF_MAX_VOICES = 32;
    localparam int POOL_SIZE      = 32;
    localparam int NUM_CHANNELS   = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 3'd1;
    localparam logic [REQ_W-1:0] REQ_BEND     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CTRL     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PATCH    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_ALL_OFF  = 3'd5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STOP       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_PATCH  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BEND_RANGE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BEND       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_VOLUME     = 3'd5;

    // constants of the mapping
    localparam logic [CHAN_W-1:0]  DRUM_CHAN       = 4'd9;
    localparam logic [CTL_W-1:0]   VOLUME_CTRL_NUM = 7'd7;
    localparam logic [ONOTE_W-1:0] FM_DRUM_OFFSET  = 8'd93;
    localparam logic [ONOTE_W-1:0] STD_DRUM_OFFSET = 8'd128;
    localparam logic [ONOTE_W-1:0] OCTAVE_STEP     = 8'd12;
    localparam logic [OARG_W-1:0]  BEND_RANGE_VAL  = 21'd200;
    localparam logic [OARG_W-1:0]  ALL_OFF_VEL     = 21'd64;
    localparam logic [PATCH_W-1:0] PATCH_UNSET     = 8'hFF;
    localparam int                 BEND_SHIFT      = 7;

    // volume scaling: p * scale / 100 as (p * recip) >> shift, exact for p < 2**PROD_W
    localparam int PROD_W   = ARG_W + SCALE_W;
    localparam int RECIP_W  = 22;
    localparam int VOL_SHIFT = 28;
    localparam int MULT_W   = PROD_W + RECIP_W;
    localparam int SCALED_W = MULT_W - VOL_SHIFT;
    localparam logic [RECIP_W-1:0] VOL_RECIP = 22'd2684355;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL1,
        ST_MUL2,
        ST_SCAN,
        ST_SECOND,
        ST_FLUSH
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;         // latch request, clear voice index
        logic mul_a;        // volume product stage
        logic mul_b;        // reciprocal stage
        logic idx_inc;      // next voice
        logic push_first;   // first command for this voice
        logic push_second;  // second command for this voice
        logic entry_take;   // mark voice busy with request note and channel
        logic entry_free;   // mark voice free
        logic patch_wr;     // store channel patch
        logic flush;        // release held command with last set
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             is_volume;
        logic             hit;
        logic             idx_last;
        logic             none_active;
        logic             out_free;
        logic             pend_valid;
    } dp_stat_t;

endpackage

>>> hdl/svalloc_ctrl.sv
// svalloc_ctrl: sequencer that walks the voice table and issues commands to the datapath
// depends on svalloc_pkg
`timescale 1ns / 1ps

module svalloc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  svalloc_pkg::dp_stat_t stat,
    output svalloc_pkg::dp_cmd_t  ctl
);
    import svalloc_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.none_active)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    case (stat.req) inside
                        REQ_NOTE_ON, REQ_NOTE_OFF, REQ_BEND, REQ_PATCH, REQ_ALL_OFF:
                        begin
                            state_next = ST_SCAN;
                        end
                        REQ_CTRL:
                        begin
                            state_next = stat.is_volume ? ST_MUL1 : ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL1:
            begin
                ctl.mul_a  = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                ctl.mul_b  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!stat.hit)
                begin
                    if (stat.idx_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        ctl.idx_inc = 1'b1;
                    end
                end
                else if (stat.req == REQ_PATCH)
                begin
                    ctl.patch_wr = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    ctl.push_first = 1'b1;
                    unique case (stat.req)
                        REQ_NOTE_ON:
                        begin
                            ctl.entry_take = 1'b1;
                            state_next     = ST_SECOND;
                        end
                        REQ_NOTE_OFF:
                        begin
                            ctl.entry_free = 1'b1;
                            state_next     = ST_FLUSH;
                        end
                        REQ_BEND:
                        begin
                            state_next = ST_SECOND;
                        end
                        REQ_ALL_OFF:
                        begin
                            ctl.entry_free = 1'b1;
                            if (stat.idx_last)
                            begin
                                state_next = ST_FLUSH;
                            end
                            else
                            begin
                                ctl.idx_inc = 1'b1;
                            end
                        end
                        default:
                        begin
                            // volume: one command per matching voice
                            if (stat.idx_last)
                            begin
                                state_next = ST_FLUSH;
                            end
                            else
                            begin
                                ctl.idx_inc = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_SECOND:
            begin
                if (stat.out_free)
                begin
                    ctl.push_second = 1'b1;
                    if (stat.req == REQ_NOTE_ON || stat.idx_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        ctl.idx_inc = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    ctl.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/svalloc_dp.sv
// svalloc_dp: configuration, request latch, voice table, channel patches, volume scaler, output
// depends on svalloc_pkg; driven by svalloc_ctrl through dp_cmd_t
`timescale 1ns / 1ps

module svalloc_dp #(
    parameter int MAX_VOICES = svalloc_pkg::DEF_MAX_VOICES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [svalloc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [svalloc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [svalloc_pkg::REQ_W-1:0]       req_type,
    input  logic [svalloc_pkg::NOTE_W-1:0]      note_num,
    input  logic [svalloc_pkg::CHAN_W-1:0]      chan,
    input  logic [svalloc_pkg::ARG_W-1:0]       arg_value,
    input  logic [svalloc_pkg::CTL_W-1:0]       ctrl_num,
    input  svalloc_pkg::dp_cmd_t                ctl,
    output svalloc_pkg::dp_stat_t               stat,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [svalloc_pkg::CMD_W-1:0]       cmd,
    output logic [svalloc_pkg::VIDX_W-1:0]      voice_idx,
    output logic [svalloc_pkg::ONOTE_W-1:0]     out_note,
    output logic [svalloc_pkg::OARG_W-1:0]      out_arg,
    output logic                                last
);
    import svalloc_pkg::*;

    localparam int VOICE_SLOTS = (MAX_VOICES < POOL_SIZE) ? MAX_VOICES : POOL_SIZE;
    localparam int IDX_W       = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;

    // configuration
    logic [VIU_W-1:0]   voices_in_use_reg;
    logic               fm_drum_mode_reg;
    logic               octave_shift_reg;
    logic [SCALE_W-1:0] master_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voices_in_use_reg <= RESET_VOICES;
            fm_drum_mode_reg  <= 1'b0;
            octave_shift_reg  <= 1'b0;
            master_scale_reg  <= RESET_SCALE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VOICES_IN_USE: voices_in_use_reg <= cfg_data[VIU_W-1:0];
                CFG_FM_DRUM_MODE:  fm_drum_mode_reg  <= cfg_data[0];
                CFG_OCTAVE_SHIFT:  octave_shift_reg  <= cfg_data[0];
                CFG_MASTER_SCALE:  master_scale_reg  <= cfg_data[SCALE_W-1:0];
                default:           ;
            endcase
        end
    end

    // request latch and voice index
    logic [REQ_W-1:0]  rq_type_reg;
    logic [NOTE_W-1:0] rq_note_reg;
    logic [CHAN_W-1:0] rq_chan_reg;
    logic [ARG_W-1:0]  rq_arg_reg;
    logic              rq_vol_reg;
    logic [IDX_W-1:0]  idx_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rq_type_reg <= req_type;
            rq_note_reg <= note_num;
            rq_chan_reg <= chan;
            rq_arg_reg  <= arg_value;
            rq_vol_reg  <= (ctrl_num == VOLUME_CTRL_NUM);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (ctl.load)
        begin
            idx_reg <= '0;
        end
        else if (ctl.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    logic [VIU_W-1:0] n_active;
    assign n_active = (voices_in_use_reg > VIU_W'(VOICE_SLOTS)) ? VIU_W'(VOICE_SLOTS)
                                                                 : voices_in_use_reg;

    // voice table
    logic [VOICE_SLOTS-1:0] busy_reg;
    logic [NOTE_W-1:0]      vnote_reg [VOICE_SLOTS];
    logic [CHAN_W-1:0]      vchan_reg [VOICE_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else if (ctl.entry_take)
        begin
            busy_reg[idx_reg] <= 1'b1;
        end
        else if (ctl.entry_free)
        begin
            busy_reg[idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.entry_take)
        begin
            vnote_reg[idx_reg] <= rq_note_reg;
            vchan_reg[idx_reg] <= rq_chan_reg;
        end
    end

    logic              cur_busy;
    logic [NOTE_W-1:0] cur_note;
    logic [CHAN_W-1:0] cur_chan;
    logic              chan_match;
    logic              hit;

    assign cur_busy   = busy_reg[idx_reg];
    assign cur_note   = vnote_reg[idx_reg];
    assign cur_chan   = vchan_reg[idx_reg];
    assign chan_match = (cur_chan == rq_chan_reg);

    always_comb
    begin
        unique case (rq_type_reg)
            REQ_NOTE_ON:  hit = !cur_busy;
            REQ_NOTE_OFF: hit = cur_busy && chan_match && (cur_note == rq_note_reg);
            REQ_BEND:     hit = cur_busy && chan_match;
            REQ_CTRL:     hit = cur_busy && chan_match;
            REQ_PATCH:    hit = !cur_busy || chan_match;
            REQ_ALL_OFF:  hit = cur_busy;
            default:      hit = 1'b0;
        endcase
    end

    // channel patches
    logic [PATCH_W-1:0] patch_reg [NUM_CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                patch_reg[i] <= PATCH_UNSET;
            end
        end
        else if (ctl.patch_wr)
        begin
            patch_reg[rq_chan_reg] <= rq_arg_reg[PATCH_W-1:0];
        end
    end

    // volume scaler, two registered multiplies
    logic [PROD_W-1:0]   prod_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [MULT_W-1:0]   recip_prod;

    assign recip_prod = MULT_W'(prod_reg) * MULT_W'(VOL_RECIP);

    always_ff @(posedge clk)
    begin
        if (ctl.mul_a)
        begin
            prod_reg <= PROD_W'(rq_arg_reg) * PROD_W'(master_scale_reg);
        end
        if (ctl.mul_b)
        begin
            scaled_reg <= recip_prod[MULT_W-1:VOL_SHIFT];
        end
    end

    // command payloads
    logic               is_drum;
    logic [ONOTE_W-1:0] drum_patch;
    logic [ONOTE_W-1:0] start_note;
    logic [CMD_W-1:0]   new_cmd;
    logic [ONOTE_W-1:0] new_note;
    logic [OARG_W-1:0]  new_arg;

    assign is_drum    = (rq_chan_reg == DRUM_CHAN);
    assign drum_patch = ONOTE_W'(rq_note_reg)
                        + (fm_drum_mode_reg ? FM_DRUM_OFFSET : STD_DRUM_OFFSET);
    assign start_note = (!is_drum && octave_shift_reg) ? ONOTE_W'(rq_note_reg) + OCTAVE_STEP
                                                       : ONOTE_W'(rq_note_reg);

    always_comb
    begin
        new_cmd  = CMD_STOP;
        new_note = '0;
        new_arg  = '0;
        if (ctl.push_second)
        begin
            if (rq_type_reg == REQ_NOTE_ON)
            begin
                new_cmd  = CMD_START;
                new_note = start_note;
                new_arg  = OARG_W'(rq_arg_reg);
            end
            else
            begin
                new_cmd = CMD_BEND;
                new_arg = OARG_W'(rq_arg_reg) << BEND_SHIFT;
            end
        end
        else
        begin
            unique case (rq_type_reg)
                REQ_NOTE_ON:
                begin
                    new_cmd = CMD_SET_PATCH;
                    new_arg = is_drum ? OARG_W'(drum_patch) : OARG_W'(patch_reg[rq_chan_reg]);
                end
                REQ_NOTE_OFF:
                begin
                    new_cmd  = CMD_STOP;
                    new_note = ONOTE_W'(rq_note_reg);
                    new_arg  = OARG_W'(rq_arg_reg);
                end
                REQ_BEND:
                begin
                    new_cmd = CMD_BEND_RANGE;
                    new_arg = BEND_RANGE_VAL;
                end
                REQ_CTRL:
                begin
                    new_cmd = CMD_VOLUME;
                    new_arg = OARG_W'(scaled_reg);
                end
                REQ_ALL_OFF:
                begin
                    new_cmd  = CMD_STOP;
                    new_note = ONOTE_W'(cur_note);
                    new_arg  = ALL_OFF_VEL;
                end
                default:
                begin
                    new_cmd = CMD_STOP;
                end
            endcase
        end
    end

    // held command and output register; the held beat learns its last flag from what follows
    logic               push;
    logic               out_load;
    logic               pend_valid_reg;
    logic [CMD_W-1:0]   pend_cmd_reg;
    logic [VIDX_W-1:0]  pend_vidx_reg;
    logic [ONOTE_W-1:0] pend_note_reg;
    logic [OARG_W-1:0]  pend_arg_reg;
    logic               out_valid_reg;
    logic [CMD_W-1:0]   out_cmd_reg;
    logic [VIDX_W-1:0]  out_vidx_reg;
    logic [ONOTE_W-1:0] out_note_reg;
    logic [OARG_W-1:0]  out_arg_reg;
    logic               out_last_reg;

    assign push     = ctl.push_first || ctl.push_second;
    assign out_load = pend_valid_reg && (push || ctl.flush);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (ctl.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            pend_cmd_reg  <= new_cmd;
            pend_vidx_reg <= VIDX_W'(idx_reg);
            pend_note_reg <= new_note;
            pend_arg_reg  <= new_arg;
        end
        if (out_load)
        begin
            out_cmd_reg  <= pend_cmd_reg;
            out_vidx_reg <= pend_vidx_reg;
            out_note_reg <= pend_note_reg;
            out_arg_reg  <= pend_arg_reg;
            out_last_reg <= ctl.flush;
        end
    end

    assign out_valid = out_valid_reg;
    assign cmd       = out_cmd_reg;
    assign voice_idx = out_vidx_reg;
    assign out_note  = out_note_reg;
    assign out_arg   = out_arg_reg;
    assign last      = out_last_reg;

    // status
    assign stat.req         = rq_type_reg;
    assign stat.is_volume   = rq_vol_reg;
    assign stat.hit         = hit;
    assign stat.idx_last    = ((VIU_W'(idx_reg) + VIU_W'(1)) == n_active);
    assign stat.none_active = (n_active == '0);
    assign stat.out_free    = !out_valid_reg || out_ready;
    assign stat.pend_valid  = pend_valid_reg;

endmodule

>>> hdl/synth_voice_allocator_core.sv
// synth_voice_allocator_core: channel event to synth voice command mapper, top level
// depends on svalloc_pkg, svalloc_ctrl and svalloc_dp
`timescale 1ns / 1ps

// Maps channel events (note on/off, pitch bend, main volume, patch change, all off) onto a
// pool of up to 32 synth voices, taking the lowest free voice on note-on. One event is worked
// at a time: after the accept beat a decode state follows, then a sequencer walks the
// active voices one per cycle while out_ready does not hold it back, stopping early on
// note-on, note-off and patch change at the first hit. A voice that gets two commands
// (note-on, bend) holds the walk for its second command, and a final flush state releases
// the last command; volume changes first pass through the two scaling multiply states.
// One command is held back until the next is known so that its last flag can be
// set, and a one-beat output register lets a new event be accepted while the final command
// still waits on out_ready. Configuration must be written by the user only while no event
// is in flight; the block itself does not enforce it.

module synth_voice_allocator_core #(
    parameter int MAX_VOICES = svalloc_pkg::DEF_MAX_VOICES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [svalloc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [svalloc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // event channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [svalloc_pkg::REQ_W-1:0]       req_type,
    input  logic [svalloc_pkg::NOTE_W-1:0]      note_num,
    input  logic [svalloc_pkg::CHAN_W-1:0]      chan,
    input  logic [svalloc_pkg::ARG_W-1:0]       arg_value,
    input  logic [svalloc_pkg::CTL_W-1:0]       ctrl_num,
    // command channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [svalloc_pkg::CMD_W-1:0]       cmd,
    output logic [svalloc_pkg::VIDX_W-1:0]      voice_idx,
    output logic [svalloc_pkg::ONOTE_W-1:0]     out_note,
    output logic [svalloc_pkg::OARG_W-1:0]      out_arg,
    output logic                                last
);
    import svalloc_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    // sequencer: accept beat, decode, volume multiplies, voice walk, command issue, final flush
    svalloc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // voice table, patches, scaler and the output beat
    svalloc_dp #(
        .MAX_VOICES (MAX_VOICES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_type  (req_type),
        .note_num  (note_num),
        .chan      (chan),
        .arg_value (arg_value),
        .ctrl_num  (ctrl_num),
        .ctl       (ctl),
        .stat      (stat),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .cmd       (cmd),
        .voice_idx (voice_idx),
        .out_note  (out_note),
        .out_arg   (out_arg),
        .last      (last)
    );

endmodule
